>>> hw/rtl/smm_pkg.sv
package smm_pkg;

	// Fixed field widths
	localparam int DATA_W = 32;
	localparam int DIM_W  = 4;

	// Defaults for the top-level parameter and the dimension register
	localparam int MAX_DIM_DEFAULT = 8;
	localparam int DIM_RESET       = 2;

	// Controller to datapath commands
	typedef struct packed {
		logic wr_a;       // write the element into the first store
		logic wr_b;       // write the element into the second store
		logic mac_valid;  // read both stores and start one multiply-accumulate
		logic mac_first;  // this multiply starts a new sum
		logic push;       // load the accumulator into the output register
		logic row_end;    // flag for the pushed result
		logic last;       // pushed result ends the product matrix
	} smm_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic s1_busy;    // a multiply-accumulate is still in the read stage
		logic out_free;   // output register can take a result this cycle
	} smm_status_t;

endpackage

>>> hw/rtl/smm_cfg_if.sv
interface smm_cfg_if;
	import smm_pkg::*;

	logic             valid;
	logic             ready;
	logic [DIM_W-1:0] dimension;

	modport source (output valid, output dimension, input ready);
	modport sink (input valid, input dimension, output ready);
endinterface

>>> hw/rtl/smm_elem_if.sv
interface smm_elem_if;
	import smm_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] element;

	modport source (output valid, output element, input ready);
	modport sink (input valid, input element, output ready);
endinterface

>>> hw/rtl/smm_result_if.sv
interface smm_result_if;
	import smm_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] product_value;
	logic                     row_end;
	logic                     final_element;

	modport source (output valid, output product_value, output row_end,
		output final_element, input ready);
	modport sink (input valid, input product_value, input row_end,
		input final_element, output ready);
endinterface

>>> hw/rtl/smm_ctrl.sv
module smm_ctrl #(
	parameter int MAX_DIM = smm_pkg::MAX_DIM_DEFAULT,
	parameter int DEPTH   = MAX_DIM * MAX_DIM,
	parameter int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	input  logic [smm_pkg::DIM_W-1:0] cfg_dimension,
	output logic                      cfg_ready,
	input  logic                      elem_valid,
	output logic                      elem_ready,
	input  smm_pkg::smm_status_t      stat,
	output smm_pkg::smm_cmd_t         cmd,
	output logic [ADDR_W-1:0]         wr_addr,
	output logic [ADDR_W-1:0]         a_addr,
	output logic [ADDR_W-1:0]         b_addr
);
	import smm_pkg::*;

	localparam int CNT_W = $clog2(2 * DEPTH);
	localparam int NN_W  = CNT_W + 1;
	localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

	typedef enum logic [3:0] {
		S_LOAD  = 4'b0001,
		S_MAC   = 4'b0010,
		S_DRAIN = 4'b0100,
		S_PUSH  = 4'b1000
	} state_t;

	state_t             state_q;
	logic [DIM_W-1:0]   dimension_q;
	logic [CNT_W-1:0]   load_cnt_q;
	logic [IDX_W-1:0]   row_q, col_q, k_q;
	logic [ADDR_W-1:0]  a_base_q, a_addr_q, b_addr_q;

	logic [DIM_W-1:0]   n_eff, n_last;
	logic [NN_W-1:0]    nn, two_nn, pos, pos_next;
	logic               accept, k_last, col_last, row_last;

	// Active size, clamped to 1..MAX_DIM
	always_comb begin
		if (dimension_q == '0) begin
			n_eff = DIM_W'(1);
		end else if (dimension_q > DIM_W'(MAX_DIM)) begin
			n_eff = DIM_W'(MAX_DIM);
		end else begin
			n_eff = dimension_q;
		end
		n_last = n_eff - DIM_W'(1);
	end

	// Load position within the current pair
	always_comb begin
		nn     = NN_W'(n_eff) * NN_W'(n_eff);
		two_nn = nn << 1;
		pos    = NN_W'(load_cnt_q);
		if (pos >= two_nn) begin
			pos = '0;
		end
		pos_next = pos + NN_W'(1);
	end

	assign accept     = elem_valid && elem_ready;
	assign elem_ready = (state_q == S_LOAD);
	assign cfg_ready  = 1'b1;
	assign k_last     = (DIM_W'(k_q) == n_last);
	assign col_last   = (DIM_W'(col_q) == n_last);
	assign row_last   = (DIM_W'(row_q) == n_last);
	assign a_addr     = a_addr_q;
	assign b_addr     = b_addr_q;

	// Commands to the datapath
	always_comb begin
		cmd           = '0;
		cmd.wr_a      = accept && (pos < nn);
		cmd.wr_b      = accept && !(pos < nn);
		cmd.mac_valid = (state_q == S_MAC);
		cmd.mac_first = (k_q == '0);
		cmd.push      = (state_q == S_PUSH) && stat.out_free;
		cmd.row_end   = col_last;
		cmd.last      = col_last && row_last;
		wr_addr       = (pos < nn) ? ADDR_W'(pos) : ADDR_W'(pos - nn);
	end

	// Sequencer: load, then per product element n MACs, drain, push
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			dimension_q <= DIM_W'(DIM_RESET);
			load_cnt_q  <= '0;
			row_q       <= '0;
			col_q       <= '0;
			k_q         <= '0;
			a_base_q    <= '0;
			a_addr_q    <= '0;
			b_addr_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				dimension_q <= cfg_dimension;
				load_cnt_q  <= '0;
			end
			case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (pos_next >= two_nn) begin
							load_cnt_q <= '0;
							row_q      <= '0;
							col_q      <= '0;
							k_q        <= '0;
							a_base_q   <= '0;
							a_addr_q   <= '0;
							b_addr_q   <= '0;
							state_q    <= S_MAC;
						end else begin
							load_cnt_q <= CNT_W'(pos_next);
						end
					end
				end
				S_MAC: begin
					a_addr_q <= a_addr_q + ADDR_W'(1);
					b_addr_q <= b_addr_q + ADDR_W'(n_eff);
					k_q      <= k_q + IDX_W'(1);
					if (k_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!stat.s1_busy) begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (stat.out_free) begin
						k_q <= '0;
						if (col_last) begin
							col_q    <= '0;
							b_addr_q <= '0;
							if (row_last) begin
								state_q <= S_LOAD;
							end else begin
								row_q    <= row_q + IDX_W'(1);
								a_base_q <= a_base_q + ADDR_W'(n_eff);
								a_addr_q <= a_base_q + ADDR_W'(n_eff);
								state_q  <= S_MAC;
							end
						end else begin
							col_q    <= col_q + IDX_W'(1);
							a_addr_q <= a_base_q;
							b_addr_q <= ADDR_W'(col_q) + ADDR_W'(1);
							state_q  <= S_MAC;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/smm_datapath.sv
module smm_datapath #(
	parameter int MAX_DIM = smm_pkg::MAX_DIM_DEFAULT,
	parameter int DEPTH   = MAX_DIM * MAX_DIM,
	parameter int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  smm_pkg::smm_cmd_t                 cmd,
	input  logic [ADDR_W-1:0]                 wr_addr,
	input  logic [ADDR_W-1:0]                 a_addr,
	input  logic [ADDR_W-1:0]                 b_addr,
	input  logic signed [smm_pkg::DATA_W-1:0] wr_data,
	output smm_pkg::smm_status_t              stat,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [smm_pkg::DATA_W-1:0] out_value,
	output logic                              out_row_end,
	output logic                              out_last
);
	import smm_pkg::*;

	logic [DATA_W-1:0] mem_a_q [DEPTH];
	logic [DATA_W-1:0] mem_b_q [DEPTH];

	logic [DATA_W-1:0] rd_a_s1, rd_b_s1, prod_s2, acc_q;
	logic              v_s1, first_s1, v_s2, first_s2;
	logic              out_valid_q, out_row_end_q, out_last_q;
	logic [DATA_W-1:0] out_value_q;

	// Element stores, registered read
	always_ff @(posedge clk) begin
		if (cmd.wr_a) begin
			mem_a_q[wr_addr] <= wr_data;
		end
		if (cmd.wr_b) begin
			mem_b_q[wr_addr] <= wr_data;
		end
		rd_a_s1 <= mem_a_q[a_addr];
		rd_b_s1 <= mem_b_q[b_addr];
	end

	// Multiply stage and accumulator, low 32 bits only
	always_ff @(posedge clk) begin
		prod_s2 <= rd_a_s1 * rd_b_s1;
		if (v_s2) begin
			acc_q <= first_s2 ? prod_s2 : acc_q + prod_s2;
		end
	end

	// Stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			first_s1 <= 1'b0;
			v_s2     <= 1'b0;
			first_s2 <= 1'b0;
		end else begin
			v_s1     <= cmd.mac_valid;
			first_s1 <= cmd.mac_first;
			v_s2     <= v_s1;
			first_s2 <= first_s1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_value_q   <= acc_q;
			out_row_end_q <= cmd.row_end;
			out_last_q    <= cmd.last;
		end
	end

	assign stat.s1_busy  = v_s1;
	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign out_value     = out_value_q;
	assign out_row_end   = out_row_end_q;
	assign out_last      = out_last_q;

endmodule

>>> hw/rtl/square_matrix_multiply_core.sv
// Square signed integer matrix multiplier. Set dimension n (1..MAX_DIM, 0 reads as 1,
// larger values as MAX_DIM) while idle; any write drops a partly loaded pair. Send
// 2*n*n elements row-major, first matrix then second, one per cycle at most; the
// last one starts the product. Each of the n*n results takes n passes through the
// single multiply-accumulate unit, then a store read, a drain and a push. Results
// leave row-major from an output register with row_end and final_element flags;
// the next pair may load while the last result still waits to be taken.
module square_matrix_multiply_core #(
	parameter int MAX_DIM = smm_pkg::MAX_DIM_DEFAULT
) (
	input logic          clk,
	input logic          arst_n,
	smm_cfg_if.sink      cfg,
	smm_elem_if.sink     elem,
	smm_result_if.source result
);
	import smm_pkg::*;

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	smm_cmd_t          cmd;
	smm_status_t       stat;
	logic [ADDR_W-1:0] wr_addr, a_addr, b_addr;

	// Sequencer
	smm_ctrl #(
		.MAX_DIM (MAX_DIM),
		.DEPTH   (DEPTH),
		.ADDR_W  (ADDR_W)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg.valid),
		.cfg_dimension (cfg.dimension),
		.cfg_ready     (cfg.ready),
		.elem_valid    (elem.valid),
		.elem_ready    (elem.ready),
		.stat          (stat),
		.cmd           (cmd),
		.wr_addr       (wr_addr),
		.a_addr        (a_addr),
		.b_addr        (b_addr)
	);

	// Stores, MAC and output register
	smm_datapath #(
		.MAX_DIM (MAX_DIM),
		.DEPTH   (DEPTH),
		.ADDR_W  (ADDR_W)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.wr_addr     (wr_addr),
		.a_addr      (a_addr),
		.b_addr      (b_addr),
		.wr_data     (elem.element),
		.stat        (stat),
		.out_valid   (result.valid),
		.out_ready   (result.ready),
		.out_value   (result.product_value),
		.out_row_end (result.row_end),
		.out_last    (result.final_element)
	);

endmodule

>>> hw/rtl/smm_checker.sv
module smm_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              elem_ready,
	input logic                              res_valid,
	input logic                              res_ready,
	input logic signed [smm_pkg::DATA_W-1:0] res_value,
	input logic                              res_row_end,
	input logic                              res_last
);
	import smm_pkg::*;

	// A stalled result holds its payload
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_value)
		&& $stable(res_row_end) && $stable(res_last))
		else $error("result changed while stalled");

	// The last product element always closes a row
	a_last_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_last |-> res_row_end)
		else $error("final element without row end");

	// No loading while a result other than the final one is held
	a_no_load_mid_product: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_last |-> !elem_ready)
		else $error("element request taken mid product");

endmodule

bind square_matrix_multiply_core smm_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.elem_ready  (elem.ready),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_value   (result.product_value),
	.res_row_end (result.row_end),
	.res_last    (result.final_element)
);
